@@ rtl/lpr_pkg.sv @@
// Shared types, constants and helpers for the IPv4 longest-prefix router.
// No dependencies; used by lpr_cell and ipv4_longest_prefix_router_unit.
package lpr_pkg;

  localparam int TableDepth    = 16;
  localparam int NumInterfaces = 8;

  localparam int AddrW  = 32;
  localparam int IfW    = 3;
  localparam int BitsW  = 6;
  localparam int ConnW  = 8;
  localparam int CountW = $clog2(TableDepth + 1);

  // Verdict codes
  localparam logic [2:0] VerdictAdded   = 3'd0;
  localparam logic [2:0] VerdictFull    = 3'd1;
  localparam logic [2:0] VerdictLocal   = 3'd2;
  localparam logic [2:0] VerdictForward = 3'd3;
  localparam logic [2:0] VerdictNoRoute = 3'd4;
  localparam logic [2:0] VerdictUnconn  = 3'd5;

  // Configuration register indexes
  localparam logic [1:0] CfgRouterAddr = 2'd0;
  localparam logic [1:0] CfgConnected  = 2'd1;

  // Item kinds
  localparam logic KindAdd    = 1'b0;
  localparam logic KindPacket = 1'b1;

  // Lookup token that walks the cell chain
  typedef struct packed {
    logic             valid;
    logic [AddrW-1:0] addr;
    logic             found;
    logic [BitsW-1:0] bits;
    logic [IfW-1:0]   iface;
  } lpr_tok_t;

  function automatic logic [BitsW-1:0] ones_in(input logic [AddrW-1:0] v);
    logic [BitsW-1:0] n;
    n = '0;
    for (int k = 0; k < AddrW; k++) begin
      n = n + BitsW'(v[k]);
    end
    return n;
  endfunction

endpackage

@@ rtl/ipv4_longest_prefix_router_unit.sv @@
// IPv4 longest-prefix router: accepts one command when start is high and busy is low.
// Add route and local accept finish in StExec; a table lookup also waits in StWait
// while the search token walks the cell chain one entry per cycle.
// Throughput: one command at a time; busy drops the cycle the result is produced.
// Result is a one-cycle done_o strobe; the receiver cannot stall it.
// Reset (rst_ni low, async) empties the table and zeroes both config registers.
module ipv4_longest_prefix_router_unit (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      start,
  output logic                      busy,
  input  logic                      kind_i,
  input  logic [lpr_pkg::AddrW-1:0] address_i,
  input  logic [lpr_pkg::AddrW-1:0] net_mask_i,
  input  logic [lpr_pkg::IfW-1:0]   interface_number_i,
  input  logic                      cfg_we_i,
  input  logic [1:0]                cfg_idx_i,
  input  logic [lpr_pkg::AddrW-1:0] cfg_data_i,
  output logic                      done_o,
  output logic [2:0]                verdict_o,
  output logic [lpr_pkg::IfW-1:0]   out_interface_o,
  output logic [lpr_pkg::BitsW-1:0] prefix_bits_o
);

  // Sequencer states
  localparam logic [1:0] StIdle = 2'd0;
  localparam logic [1:0] StExec = 2'd1;
  localparam logic [1:0] StWait = 2'd2;

  logic [1:0] state_q, state_d;

  // Config registers
  logic [lpr_pkg::AddrW-1:0] router_addr_q;
  logic [lpr_pkg::ConnW-1:0] connected_q;

  // Latched command
  logic                      req_kind_q;
  logic [lpr_pkg::AddrW-1:0] req_addr_q;
  logic [lpr_pkg::AddrW-1:0] req_mask_q;
  logic [lpr_pkg::IfW-1:0]   req_if_q;

  logic [lpr_pkg::CountW-1:0] count_q, count_d;

  logic                      accept;
  logic                      add_fire;
  logic                      table_full;
  logic [lpr_pkg::BitsW-1:0] req_bits;

  // Result register
  logic                      done_q, done_d;
  logic [2:0]                verdict_q, verdict_d;
  logic [lpr_pkg::IfW-1:0]   out_if_q, out_if_d;
  logic [lpr_pkg::BitsW-1:0] bits_q, bits_d;

  lpr_pkg::lpr_tok_t tok [lpr_pkg::TableDepth+1];
  lpr_pkg::lpr_tok_t tok_end;
  logic              end_connected;

  assign busy       = (state_q != StIdle);
  assign accept     = start && !busy;
  assign table_full = (count_q == lpr_pkg::CountW'(lpr_pkg::TableDepth));
  assign add_fire   = (state_q == StExec) && (req_kind_q == lpr_pkg::KindAdd) && !table_full;
  assign req_bits   = lpr_pkg::ones_in(req_mask_q);

  // Config writes; indexes beyond the list are dropped
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      router_addr_q <= '0;
      connected_q   <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        lpr_pkg::CfgRouterAddr: router_addr_q <= cfg_data_i;
        lpr_pkg::CfgConnected:  connected_q   <= cfg_data_i[lpr_pkg::ConnW-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      req_kind_q <= kind_i;
      req_addr_q <= address_i;
      req_mask_q <= net_mask_i;
      req_if_q   <= interface_number_i;
    end
  end

  // Token injected at the head of the chain while a lookup starts
  always_comb begin
    tok[0]       = '0;
    tok[0].addr  = req_addr_q;
    tok[0].valid = (state_q == StExec) && (req_kind_q == lpr_pkg::KindPacket) &&
                   (req_addr_q != router_addr_q);
  end

  // The cell row: entry g is written by the add that finds count == g
  for (genvar g = 0; g < lpr_pkg::TableDepth; g++) begin : g_cell
    lpr_cell u_cell (
      .clk_i     (clk_i),
      .rst_ni    (rst_ni),
      .wr_en_i   (add_fire && (count_q == lpr_pkg::CountW'(g))),
      .wr_net_i  (req_addr_q),
      .wr_mask_i (req_mask_q),
      .wr_if_i   (req_if_q),
      .wr_bits_i (req_bits),
      .tok_i     (tok[g]),
      .tok_o     (tok[g+1])
    );
  end

  assign tok_end = tok[lpr_pkg::TableDepth];
  // interfaces past NumInterfaces or the register width count as unconnected
  assign end_connected = (32'(tok_end.iface) < lpr_pkg::NumInterfaces) &&
                         (32'(tok_end.iface) < lpr_pkg::ConnW) &&
                         connected_q[tok_end.iface];

  always_comb begin
    state_d   = state_q;
    count_d   = count_q;
    done_d    = 1'b0;
    verdict_d = verdict_q;
    out_if_d  = '0;
    bits_d    = '0;
    case (state_q)
      StIdle: begin
        if (accept) begin
          state_d = StExec;
        end
      end
      StExec: begin
        if (req_kind_q == lpr_pkg::KindAdd) begin
          done_d  = 1'b1;
          state_d = StIdle;
          if (table_full) begin
            verdict_d = lpr_pkg::VerdictFull;
          end else begin
            verdict_d = lpr_pkg::VerdictAdded;
            count_d   = count_q + lpr_pkg::CountW'(1);
          end
        end else if (req_addr_q == router_addr_q) begin
          done_d    = 1'b1;
          verdict_d = lpr_pkg::VerdictLocal;
          state_d   = StIdle;
        end else begin
          state_d = StWait;
        end
      end
      StWait: begin
        if (tok_end.valid) begin
          done_d  = 1'b1;
          state_d = StIdle;
          if (!tok_end.found) begin
            verdict_d = lpr_pkg::VerdictNoRoute;
          end else begin
            out_if_d  = tok_end.iface;
            bits_d    = tok_end.bits;
            verdict_d = end_connected ? lpr_pkg::VerdictForward : lpr_pkg::VerdictUnconn;
          end
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      count_q <= '0;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
      done_q  <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    verdict_q <= verdict_d;
    out_if_q  <= out_if_d;
    bits_q    <= bits_d;
  end

  assign done_o          = done_q;
  assign verdict_o       = verdict_q;
  assign out_interface_o = out_if_q;
  assign prefix_bits_o   = bits_q;

endmodule

@@ rtl/lpr_cell.sv @@
// One route-table entry plus one stage of the lookup chain.
// Depends on lpr_pkg (token type, field widths).
module lpr_cell (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         wr_en_i,
  input  logic [lpr_pkg::AddrW-1:0]    wr_net_i,
  input  logic [lpr_pkg::AddrW-1:0]    wr_mask_i,
  input  logic [lpr_pkg::IfW-1:0]      wr_if_i,
  input  logic [lpr_pkg::BitsW-1:0]    wr_bits_i,
  input  lpr_pkg::lpr_tok_t            tok_i,
  output lpr_pkg::lpr_tok_t            tok_o
);

  logic                      valid_q;
  logic [lpr_pkg::AddrW-1:0] net_q;
  logic [lpr_pkg::AddrW-1:0] mask_q;
  logic [lpr_pkg::IfW-1:0]   if_q;
  logic [lpr_pkg::BitsW-1:0] bits_q;
  logic                      tok_valid_q;
  lpr_pkg::lpr_tok_t         tok_d, tok_q;
  logic                      hit;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (wr_en_i) begin
      valid_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      net_q  <= wr_net_i;
      mask_q <= wr_mask_i;
      if_q   <= wr_if_i;
      bits_q <= wr_bits_i;
    end
  end

  // later entries win ties, hence >=
  assign hit = valid_q && ((tok_i.addr & mask_q) == net_q) &&
               (!tok_i.found || (bits_q >= tok_i.bits));

  always_comb begin
    tok_d = tok_i;
    if (hit) begin
      tok_d.found = 1'b1;
      tok_d.bits  = bits_q;
      tok_d.iface = if_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tok_valid_q <= 1'b0;
    end else begin
      tok_valid_q <= tok_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    tok_q <= tok_d;
  end

  always_comb begin
    tok_o       = tok_q;
    tok_o.valid = tok_valid_q;
  end

endmodule

@@ tb/ipv4_longest_prefix_router_unit_tb.sv @@
`timescale 1ns / 1ps
// Self-checking testbench for ipv4_longest_prefix_router_unit: directed route and
// packet commands, then four randomized traffic phases under changing register settings.
// Depends on lpr_pkg and the router RTL only.
module ipv4_longest_prefix_router_unit_tb;
  import lpr_pkg::*;

  localparam int          CLK_PERIOD     = 10;
  localparam int          RESET_CYCLES   = 6;
  localparam int          WATCHDOG_LIMIT = 5000;
  // Register indexes past the two real registers; writes there must be dropped.
  localparam logic [1:0]  CfgSpareLo     = 2'd2;
  localparam logic [1:0]  CfgSpareHi     = 2'd3;

  // One result as the router reports it.
  typedef struct packed {
    logic [2:0]       verdict;
    logic [IfW-1:0]   iface;
    logic [BitsW-1:0] bits;
  } route_result_t;

  // ---------------------------------------------------------------------------
  // Route scoreboard: keeps its own copy of the route table and the two
  // registers, works out the verdict of every accepted command and checks the
  // results against those verdicts in order.
  // ---------------------------------------------------------------------------
  class route_scoreboard;
    logic [AddrW-1:0] own_addr;
    logic [ConnW-1:0] linked_ifs;
    logic [AddrW-1:0] tbl_net  [TableDepth];
    logic [AddrW-1:0] tbl_mask [TableDepth];
    logic [IfW-1:0]   tbl_if   [TableDepth];
    int unsigned      n_routes;
    route_result_t    verdict_q[$];
    int unsigned      n_checked;
    int unsigned      n_errors;
    int unsigned      verdict_cnt[6];

    function new();
      own_addr   = '0;
      linked_ifs = '0;
      n_routes   = 0;
      n_checked  = 0;
      n_errors   = 0;
      foreach (verdict_cnt[k]) verdict_cnt[k] = 0;
    endfunction

    function void write_reg(logic [1:0] idx, logic [AddrW-1:0] data);
      case (idx)
        CfgRouterAddr: own_addr = data;
        CfgConnected:  linked_ifs = data[ConnW-1:0];
        default: ;  // spare index: no register behind it
      endcase
    endfunction

    function int unsigned prefix_len(logic [AddrW-1:0] m);
      int unsigned n;
      n = 0;
      for (int k = 0; k < AddrW; k++) n += m[k];
      return n;
    endfunction

    // Called once per accepted command.
    function void note_command(logic kind, logic [AddrW-1:0] addr, logic [AddrW-1:0] mask,
                               logic [IfW-1:0] ifn);
      route_result_t want;
      logic          hit;
      int unsigned   len;
      want = '0;
      if (kind == KindAdd) begin
        if (n_routes >= TableDepth) begin
          want.verdict = VerdictFull;
        end else begin
          tbl_net[n_routes]  = addr;
          tbl_mask[n_routes] = mask;
          tbl_if[n_routes]   = ifn;
          n_routes++;
          want.verdict = VerdictAdded;
        end
      end else if (addr == own_addr) begin
        // own address wins even over a matching route
        want.verdict = VerdictLocal;
      end else begin
        hit = 1'b0;
        for (int i = 0; i < n_routes; i++) begin
          if ((addr & tbl_mask[i]) == tbl_net[i]) begin
            len = prefix_len(tbl_mask[i]);
            // >= so that a later entry of equal length takes over
            if (!hit || len >= want.bits) begin
              hit        = 1'b1;
              want.bits  = BitsW'(len);
              want.iface = tbl_if[i];
            end
          end
        end
        if (!hit) begin
          want.verdict = VerdictNoRoute;
        end else if (want.iface < NumInterfaces && linked_ifs[want.iface]) begin
          want.verdict = VerdictForward;
        end else begin
          want.verdict = VerdictUnconn;
        end
      end
      verdict_cnt[want.verdict]++;
      verdict_q = {verdict_q, want};
    endfunction

    function void compare_field(string fld, logic [7:0] want, logic [7:0] got);
      if (got !== want) begin
        $display("%0t MISMATCH %s: expected %0d, actual %0d", $time, fld, want, got);
        n_errors++;
      end
    endfunction

    // Called once per result strobe.
    function void check_result(logic [2:0] verdict, logic [IfW-1:0] iface,
                               logic [BitsW-1:0] bits);
      route_result_t want;
      if (verdict_q.size() == 0) begin
        $display("%0t ERROR result with no command outstanding: expected none, actual %0d/%0d/%0d",
                 $time, verdict, iface, bits);
        n_errors++;
        return;
      end
      want = verdict_q.pop_front();
      n_checked++;
      compare_field("verdict", 8'(want.verdict), 8'(verdict));
      compare_field("out_interface", 8'(want.iface), 8'(iface));
      compare_field("prefix_bits", 8'(want.bits), 8'(bits));
    endfunction

    function int unsigned pending();
      return verdict_q.size();
    endfunction
  endclass

  // ---------------------------------------------------------------------------
  // DUT and its signals; every input has a known value from time zero.
  // ---------------------------------------------------------------------------
  logic             clk_i              = 1'b0;
  logic             rst_ni             = 1'b0;
  logic             start              = 1'b0;
  logic             busy;
  logic             kind_i             = KindPacket;
  logic [AddrW-1:0] address_i          = '0;
  logic [AddrW-1:0] net_mask_i         = '0;
  logic [IfW-1:0]   interface_number_i = '0;
  logic             cfg_we_i           = 1'b0;
  logic [1:0]       cfg_idx_i          = CfgRouterAddr;
  logic [AddrW-1:0] cfg_data_i         = '0;
  logic             done_o;
  logic [2:0]       verdict_o;
  logic [IfW-1:0]   out_interface_o;
  logic [BitsW-1:0] prefix_bits_o;

  ipv4_longest_prefix_router_unit u_dut (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .start              (start),
    .busy               (busy),
    .kind_i             (kind_i),
    .address_i          (address_i),
    .net_mask_i         (net_mask_i),
    .interface_number_i (interface_number_i),
    .cfg_we_i           (cfg_we_i),
    .cfg_idx_i          (cfg_idx_i),
    .cfg_data_i         (cfg_data_i),
    .done_o             (done_o),
    .verdict_o          (verdict_o),
    .out_interface_o    (out_interface_o),
    .prefix_bits_o      (prefix_bits_o)
  );

  always #(CLK_PERIOD / 2) clk_i = ~clk_i;

  route_scoreboard sb;
  int unsigned     quiet_cycles = 0;

  // Stimulus-side view of what was sent, used only to aim packets at routes.
  logic [AddrW-1:0] sent_net[$];
  logic [AddrW-1:0] sent_mask[$];
  logic [AddrW-1:0] cur_router = '0;

  // ---------------------------------------------------------------------------
  // Monitor. Runs at every rising edge and sees the values that were present
  // before the edge, so result checks, register writes and command transfers
  // are all taken in a fixed order within the edge. Also runs the watchdog:
  // a long stretch with no transfer of any kind ends the run.
  // ---------------------------------------------------------------------------
  always @(posedge clk_i) begin
    if (rst_ni) begin
      quiet_cycles++;
      if (done_o) begin
        sb.check_result(verdict_o, out_interface_o, prefix_bits_o);
        quiet_cycles = 0;
      end
      if (cfg_we_i) begin
        sb.write_reg(cfg_idx_i, cfg_data_i);
        quiet_cycles = 0;
      end
      if (start && !busy) begin
        sb.note_command(kind_i, address_i, net_mask_i, interface_number_i);
        quiet_cycles = 0;
      end
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("%0t watchdog: no transfer in %0d cycles, %0d results outstanding",
                 $time, quiet_cycles, sb.pending());
        $display("Regression FAIL");
        $finish;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Driver tasks. All of them are entered and left at a rising edge, and all
  // drive with nonblocking assignments at that edge.
  // ---------------------------------------------------------------------------

  // Present one command and hold it until the transfer edge (start high, busy low).
  // start stays high on return so back-to-back commands keep it asserted.
  task automatic send_cmd(input logic kind, input logic [AddrW-1:0] addr,
                          input logic [AddrW-1:0] mask, input logic [IfW-1:0] ifn);
    start              <= 1'b1;
    kind_i             <= kind;
    address_i          <= addr;
    net_mask_i         <= mask;
    interface_number_i <= ifn;
    if (kind == KindAdd && sent_net.size() < TableDepth) begin
      sent_net  = {sent_net, addr};
      sent_mask = {sent_mask, mask};
    end
    do @(posedge clk_i); while (busy);
  endtask

  task automatic idle_cycle();
    start <= 1'b0;
    @(posedge clk_i);
  endtask

  // Hold off the sender until every outstanding result has come back. The
  // count is read at falling edges, clear of the monitor's updates.
  task automatic drain();
    start <= 1'b0;
    @(negedge clk_i);
    while (sb.pending() != 0) @(negedge clk_i);
    @(posedge clk_i);
  endtask

  // Back-to-back register writes; the spare indexes get junk that must be ignored.
  task automatic set_config(input logic [AddrW-1:0] router, input logic [ConnW-1:0] conn);
    logic [1:0]       idx  [4];
    logic [AddrW-1:0] data [4];
    idx[0]  = CfgRouterAddr;  data[0] = router;
    idx[1]  = CfgConnected;   data[1] = {(AddrW-ConnW)'($urandom), conn};
    idx[2]  = CfgSpareLo;     data[2] = $urandom;
    idx[3]  = CfgSpareHi;     data[3] = ~router;
    cur_router = router;
    for (int k = 0; k < 4; k++) begin
      cfg_we_i   <= 1'b1;
      cfg_idx_i  <= idx[k];
      cfg_data_i <= data[k];
      @(posedge clk_i);
    end
    cfg_we_i <= 1'b0;
  endtask

  // Random route: mostly contiguous masks, often nested in or equal to an
  // existing route so longest-match and ties get exercised.
  function automatic void make_route(output logic [AddrW-1:0] net, output logic [AddrW-1:0] msk);
    int unsigned r;
    int unsigned j;
    r   = $urandom_range(99);
    msk = ~(32'hFFFF_FFFF >> $urandom_range(1, 32));
    net = $urandom & msk;
    if (sent_net.size() > 0) j = $urandom_range(sent_net.size() - 1);
    if (r < 20 && sent_net.size() > 0) begin
      msk = sent_mask[j];           // same prefix again: later entry must win
      net = sent_net[j];
    end else if (r < 50 && sent_net.size() > 0) begin
      net = sent_net[j] & msk;      // shorter or longer prefix over the same network
    end else if (r < 60) begin
      msk = $urandom;               // non-contiguous mask
      net = $urandom & msk;
    end else if (r < 65) begin
      net = $urandom;               // random network, usually with bits outside the mask: seldom matches
    end
  endfunction

  // Packet destination: own address, an address inside a known route (sometimes
  // with one bit flipped to land just outside), or anything at all.
  function automatic logic [AddrW-1:0] pick_dest();
    int unsigned      r;
    int unsigned      j;
    logic [AddrW-1:0] a;
    r = $urandom_range(99);
    if (r < 10) begin
      a = cur_router;
    end else if (r < 75 && sent_net.size() > 0) begin
      j = $urandom_range(sent_net.size() - 1);
      a = sent_net[j] | ($urandom & ~sent_mask[j]);
      if ($urandom_range(3) == 0) a = a ^ (32'd1 << $urandom_range(31));
    end else begin
      a = $urandom;
    end
    return a;
  endfunction

  // One traffic phase. Adds are sparse while the table is below route_cap so
  // the table fills over the phases; once the cap reaches TableDepth adds
  // keep coming and must all be refused.
  task automatic run_phase(input int unsigned n_items, input int unsigned idle_pct,
                           input int unsigned route_cap, input int unsigned add_pct);
    logic [AddrW-1:0] net;
    logic [AddrW-1:0] msk;
    for (int k = 0; k < n_items; k++) begin
      while ($urandom_range(99) < idle_pct) idle_cycle();
      if ($urandom_range(99) == 0) drain();
      if ($urandom_range(99) < add_pct &&
          (sent_net.size() < route_cap || route_cap >= TableDepth)) begin
        make_route(net, msk);
        send_cmd(KindAdd, net, msk, IfW'($urandom_range(7)));
      end else begin
        send_cmd(KindPacket, pick_dest(), $urandom, IfW'($urandom_range(7)));
      end
    end
  endtask

  // ---------------------------------------------------------------------------
  // Test sequence
  // ---------------------------------------------------------------------------
  initial begin
    logic [AddrW-1:0] net;
    logic [AddrW-1:0] msk;
    sb = new();
    repeat (RESET_CYCLES) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Own address 10.1.2.3 sits inside routes added below; only 1, 2, 6 linked.
    set_config(32'h0A01_0203, 8'b0100_0110);

    // Empty table: own address, then a miss.
    send_cmd(KindPacket, 32'h0A01_0203, '0, '0);
    send_cmd(KindPacket, 32'h0102_0304, '1, '1);
    // Table contents for the directed lookups.
    send_cmd(KindAdd, 32'h0A00_0000, 32'hFF00_0000, 3'd1);  // 10/8
    send_cmd(KindAdd, 32'h0A01_0000, 32'hFFFF_0000, 3'd2);  // 10.1/16
    send_cmd(KindAdd, 32'h0A01_0000, 32'hFFFF_0000, 3'd6);  // same /16, later wins
    send_cmd(KindAdd, 32'hC0A8_0100, 32'hFFFF_FF00, 3'd7);  // /24 on an unlinked port
    send_cmd(KindAdd, 32'h0A00_00FF, 32'hFF00_0000, 3'd3);  // host bits set: dead entry
    send_cmd(KindAdd, 32'hC0A8_0105, 32'hFFFF_FFFF, 3'd5);  // /32 host route
    send_cmd(KindAdd, 32'hA0A0_A0A0, 32'hF0F0_F0F0, 3'd0);  // non-contiguous mask
    send_cmd(KindAdd, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 3'd4);  // all-ones host route
    // Lookups.
    send_cmd(KindPacket, 32'h0A02_0304, '0, '0);            // /8 only
    send_cmd(KindPacket, 32'h0A01_0909, '0, '0);            // /16 tie
    send_cmd(KindPacket, 32'h0A01_0203, '1, '1);            // own address beats routes
    send_cmd(KindPacket, 32'hC0A8_0105, '0, '0);            // /32 over /24, unlinked
    send_cmd(KindPacket, 32'hC0A8_0109, '0, '0);            // /24, unlinked
    send_cmd(KindPacket, 32'h0A00_00FF, '1, 3'd7);          // dead entry skipped
    send_cmd(KindPacket, 32'hFFFF_FFFF, '0, '0);            // all-ones host route
    send_cmd(KindPacket, 32'h0000_0000, '1, '1);            // nothing matches
    send_cmd(KindPacket, 32'hA5A5_A5A5, '0, '0);            // non-contiguous match
    drain();

    // Phase 0: no idling, own address zero, nothing linked.
    set_config('0, '0);
    run_phase(320, 0, 11, 4);
    drain();

    // Phase 1: sender idle most of the time, all-ones address, all linked.
    set_config('1, '1);
    run_phase(320, 76, 13, 4);
    drain();

    // Phase 2: back to full rate, random settings.
    set_config($urandom, ConnW'($urandom));
    run_phase(320, 0, 15, 4);
    drain();

    // Phase 3: top the table up, finish it with a default route, then keep
    // hitting it with adds that must be refused.
    set_config(32'h0A00_0000 | ($urandom & 32'h00FF_FFFF), 8'h5A);
    while (sent_net.size() < TableDepth - 1) begin
      make_route(net, msk);
      send_cmd(KindAdd, net, msk, IfW'($urandom_range(7)));
    end
    send_cmd(KindAdd, '0, '0, 3'd4);
    run_phase(320, 32, TableDepth, 8);
    drain();

    // Keep the clock running past the drain to catch stray strobes.
    repeat (TableDepth + 4) @(posedge clk_i);

    $display("Summary: %0d commands checked, directed traffic plus four random phases, %0d errors",
             sb.n_checked, sb.n_errors);
    $display("  verdicts: added %0d, full %0d, local %0d, forwarded %0d, no route %0d, unlinked %0d",
             sb.verdict_cnt[VerdictAdded], sb.verdict_cnt[VerdictFull],
             sb.verdict_cnt[VerdictLocal], sb.verdict_cnt[VerdictForward],
             sb.verdict_cnt[VerdictNoRoute], sb.verdict_cnt[VerdictUnconn]);
    if (sb.pending() != 0) begin
      $display("%0t ERROR results never arrived: expected 0 outstanding, actual %0d",
               $time, sb.pending());
    end
    if (sb.n_errors == 0 && sb.pending() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
rtl/lpr_pkg.sv
rtl/lpr_cell.sv
rtl/ipv4_longest_prefix_router_unit.sv
tb/ipv4_longest_prefix_router_unit_tb.sv
